// File: hw/rtl/fsbd_pkg.sv
// Shared types and constants for the flux stream byte decoder.
package fsbd_pkg;

  // Parser phase: what the next byte of the stream is expected to be.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LONG   = 2'd1,
    PH_OPCODE = 2'd2,
    PH_DATA   = 2'd3
  } phase_t;

  // Kind of a result transaction.
  typedef enum logic [1:0] {
    KIND_FLUX  = 2'd0,
    KIND_INDEX = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  localparam logic [1:0] ERR_NONE           = 2'd0;
  localparam logic [1:0] ERR_NOT_TERMINATED = 2'd1;
  localparam logic [1:0] ERR_UNEXPECTED_END = 2'd2;
  localparam logic [1:0] ERR_BAD_OPCODE     = 2'd3;

  localparam logic [7:0] FLUX_LONG_MIN = 8'd250;
  localparam logic [7:0] OP_ESCAPE     = 8'd255;
  localparam logic [7:0] OP_INDEX      = 8'd1;
  localparam logic [7:0] OP_SPACE      = 8'd2;

  localparam int unsigned LONG_W      = 11;
  localparam int unsigned PACK_W      = 28;
  localparam int unsigned OUT_TICK_W  = 40;
  localparam logic [LONG_W-1:0] LONG_STEP = 11'd255;
  localparam logic [LONG_W-1:0] LONG_MIN  = 11'd250;

  // Parser control state that travels between the top level and the step logic.
  typedef struct packed {
    phase_t     phase;
    logic [1:0] bytes_left;
    logic [1:0] opcode_held;
    logic       error_seen;
  } ctrl_t;

  // Control fields of one result.
  typedef struct packed {
    kind_t      kind;
    logic [1:0] code;
    logic       eos;
  } res_t;

endpackage

// File: hw/rtl/fsbd_step.sv
// Single-byte step of the flux stream parser: next state and result for one byte.
module fsbd_step #(
  parameter int unsigned TICK_WIDTH = 40
) (
  input  fsbd_pkg::ctrl_t                 ctrl,
  input  logic [fsbd_pkg::PACK_W-1:0]     packed_word,
  input  logic [fsbd_pkg::LONG_W-1:0]     long_code_base,
  input  logic [TICK_WIDTH-1:0]           pending_ticks,
  input  logic                            index_neg,
  input  logic [TICK_WIDTH-1:0]           index_mag,
  input  logic [7:0]                      stream_byte,
  input  logic                            final_byte,
  output fsbd_pkg::ctrl_t                 ctrl_next,
  output logic [fsbd_pkg::PACK_W-1:0]     packed_word_next,
  output logic [fsbd_pkg::LONG_W-1:0]     long_code_base_next,
  output logic [TICK_WIDTH-1:0]           pending_ticks_next,
  output logic                            index_neg_next,
  output logic [TICK_WIDTH-1:0]           index_mag_next,
  output logic                            res_valid,
  output fsbd_pkg::res_t                  res,
  output logic [fsbd_pkg::OUT_TICK_W-1:0] res_ticks
);
  import fsbd_pkg::*;

  localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

  logic [LONG_W-1:0]     long_value;
  logic [LONG_W-1:0]     flux_value;
  logic [LONG_W-1:0]     long_base_new;
  logic [PACK_W-1:0]     data_bits;
  logic [PACK_W-1:0]     packed_full;
  logic [TICK_WIDTH-1:0] add_value;
  logic [TICK_WIDTH:0]   pend_sum;
  logic [TICK_WIDTH-1:0] total;
  logic                  total_ge;
  logic [TICK_WIDTH-1:0] mag_diff;
  logic [TICK_WIDTH:0]   mag_sum;
  logic                  acc_neg;
  logic [TICK_WIDTH-1:0] acc_mag;
  logic [TICK_WIDTH-1:0] index_time;
  logic [TICK_WIDTH-1:0] tick_raw;
  logic [TICK_WIDTH+OUT_TICK_W-1:0] tick_ext;

  assign long_value    = long_code_base + {3'b000, stream_byte} - LONG_W'(1);
  assign long_base_new = LONG_MIN + LONG_W'(stream_byte - FLUX_LONG_MIN) * LONG_STEP;
  assign flux_value    = (ctrl.phase == PH_LONG) ? long_value : {3'b000, stream_byte};

  // Seven payload bits per byte, least significant group first.
  always_comb begin
    case (ctrl.bytes_left)
      2'd3:    data_bits = {21'd0, stream_byte[7:1]};
      2'd2:    data_bits = {14'd0, stream_byte[7:1], 7'd0};
      2'd1:    data_bits = {7'd0, stream_byte[7:1], 14'd0};
      default: data_bits = {stream_byte[7:1], 21'd0};
    endcase
  end
  assign packed_full = packed_word | data_bits;

  assign add_value = (ctrl.phase == PH_DATA)
                   ? {{(TICK_WIDTH-PACK_W){1'b0}}, packed_full}
                   : {{(TICK_WIDTH-LONG_W){1'b0}}, flux_value};
  assign pend_sum  = {1'b0, pending_ticks} + {1'b0, add_value};
  assign total     = pend_sum[TICK_WIDTH] ? TICK_MAX : pend_sum[TICK_WIDTH-1:0];

  // The index accumulator is sign and magnitude; a negative value is the part
  // of the last index interval that has not yet been covered by flux time.
  assign total_ge = total >= index_mag;
  assign mag_diff = total_ge ? (total - index_mag) : (index_mag - total);
  assign mag_sum  = {1'b0, index_mag} + {1'b0, total};
  assign acc_neg  = index_neg && !total_ge;
  assign acc_mag  = index_neg ? mag_diff
                  : (mag_sum[TICK_WIDTH] ? TICK_MAX : mag_sum[TICK_WIDTH-1:0]);
  assign index_time = acc_neg ? '0 : acc_mag;

  // Next state.
  always_comb begin
    ctrl_next           = ctrl;
    packed_word_next    = packed_word;
    long_code_base_next = long_code_base;
    pending_ticks_next  = pending_ticks;
    index_neg_next      = index_neg;
    index_mag_next      = index_mag;
    if (final_byte) begin
      ctrl_next           = '{phase: PH_IDLE, bytes_left: 2'd0, opcode_held: 2'd0,
                              error_seen: 1'b0};
      packed_word_next    = '0;
      long_code_base_next = '0;
      pending_ticks_next  = '0;
      index_neg_next      = 1'b0;
      index_mag_next      = '0;
    end else if (!ctrl.error_seen) begin
      case (ctrl.phase)
        PH_IDLE: begin
          if (stream_byte < FLUX_LONG_MIN) begin
            pending_ticks_next = '0;
            index_neg_next     = acc_neg;
            index_mag_next     = acc_mag;
          end else if (stream_byte == OP_ESCAPE) begin
            ctrl_next.phase = PH_OPCODE;
          end else begin
            long_code_base_next = long_base_new;
            ctrl_next.phase     = PH_LONG;
          end
        end
        PH_LONG: begin
          ctrl_next.phase    = PH_IDLE;
          pending_ticks_next = '0;
          index_neg_next     = acc_neg;
          index_mag_next     = acc_mag;
        end
        PH_OPCODE: begin
          if (stream_byte inside {OP_INDEX, OP_SPACE}) begin
            ctrl_next.opcode_held = stream_byte[1:0];
            ctrl_next.bytes_left  = 2'd3;
            ctrl_next.phase       = PH_DATA;
            packed_word_next      = '0;
          end else begin
            ctrl_next.phase      = PH_IDLE;
            ctrl_next.error_seen = 1'b1;
          end
        end
        default: begin
          packed_word_next = packed_full;
          if (ctrl.bytes_left != 2'd0) begin
            ctrl_next.bytes_left = ctrl.bytes_left - 2'd1;
          end else begin
            ctrl_next.phase = PH_IDLE;
            if (ctrl.opcode_held == OP_SPACE[1:0]) begin
              pending_ticks_next = total;
            end else begin
              // The new index interval starts owing the time already counted.
              index_neg_next = total != '0;
              index_mag_next = total;
            end
          end
        end
      endcase
    end
  end

  // Result.
  always_comb begin
    res_valid = 1'b0;
    res       = '{kind: KIND_FLUX, code: ERR_NONE, eos: 1'b0};
    tick_raw  = '0;
    if (final_byte) begin
      res_valid = 1'b1;
      res.eos   = 1'b1;
      res.kind  = KIND_ERROR;
      if (stream_byte != 8'd0) begin
        res.code = ERR_NOT_TERMINATED;
      end else if (ctrl.error_seen) begin
        res.code = ERR_BAD_OPCODE;
      end else if (ctrl.phase != PH_IDLE) begin
        res.code = ERR_UNEXPECTED_END;
      end else begin
        res.kind = KIND_DONE;
      end
    end else if (!ctrl.error_seen) begin
      case (ctrl.phase)
        PH_IDLE: begin
          if (stream_byte < FLUX_LONG_MIN) begin
            res_valid = 1'b1;
            tick_raw  = total;
          end
        end
        PH_LONG: begin
          res_valid = 1'b1;
          tick_raw  = total;
        end
        PH_OPCODE: begin
          if (!(stream_byte inside {OP_INDEX, OP_SPACE})) begin
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.code  = ERR_BAD_OPCODE;
          end
        end
        default: begin
          if (ctrl.bytes_left == 2'd0 && ctrl.opcode_held != OP_SPACE[1:0]) begin
            res_valid = 1'b1;
            res.kind  = KIND_INDEX;
            tick_raw  = index_time;
          end
        end
      endcase
    end
  end

  assign tick_ext  = {{OUT_TICK_W{1'b0}}, tick_raw};
  assign res_ticks = tick_ext[OUT_TICK_W-1:0];

endmodule

// File: hw/rtl/flux_stream_byte_decoder.sv
// Top level of the flux stream byte decoder: input register, parser state and result register.
//
// Decodes one stream byte per clock cycle while the output is not stalled, with no stalls of its
// own; each byte is held in the input register and its result, if any, is registered into the
// result register when the byte advances. The rate is set by the combinational parser step, whose
// longest path is the saturating tick add followed by the index accumulator update. The
// input register keeps taking a byte while a result waits under stall; it holds the byte
// only when that byte would itself produce a result. There is no clearing pass after reset.
module flux_stream_byte_decoder #(
  parameter int unsigned TICK_WIDTH = 40
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  stream_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [39:0] tick_value,
  output logic [1:0]  error_code,
  output logic        end_of_stream
);
  import fsbd_pkg::*;

  logic                  in_full;
  logic [7:0]            byte_q;
  logic                  byte_last_q;
  logic                  in_accept;
  logic                  advance;

  ctrl_t                 ctrl;
  ctrl_t                 ctrl_next;
  logic [PACK_W-1:0]     packed_word;
  logic [PACK_W-1:0]     packed_word_next;
  logic [LONG_W-1:0]     long_code_base;
  logic [LONG_W-1:0]     long_code_base_next;
  logic [TICK_WIDTH-1:0] pending_ticks;
  logic [TICK_WIDTH-1:0] pending_ticks_next;
  logic                  index_neg;
  logic                  index_neg_next;
  logic [TICK_WIDTH-1:0] index_mag;
  logic [TICK_WIDTH-1:0] index_mag_next;

  logic                  res_valid;
  res_t                  res;
  logic [OUT_TICK_W-1:0] res_ticks;
  res_t                  out_res;

  fsbd_step #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_step (
    .ctrl                (ctrl),
    .packed_word         (packed_word),
    .long_code_base      (long_code_base),
    .pending_ticks       (pending_ticks),
    .index_neg           (index_neg),
    .index_mag           (index_mag),
    .stream_byte         (byte_q),
    .final_byte          (byte_last_q),
    .ctrl_next           (ctrl_next),
    .packed_word_next    (packed_word_next),
    .long_code_base_next (long_code_base_next),
    .pending_ticks_next  (pending_ticks_next),
    .index_neg_next      (index_neg_next),
    .index_mag_next      (index_mag_next),
    .res_valid           (res_valid),
    .res                 (res),
    .res_ticks           (res_ticks)
  );

  // A held byte moves on unless it has a result and the result register is blocked.
  assign advance   = in_full && (!res_valid || !out_valid || !out_stall);
  assign in_stall  = in_full && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      byte_q      <= stream_byte;
      byte_last_q <= final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl           <= '{phase: PH_IDLE, bytes_left: 2'd0, opcode_held: 2'd0,
                          error_seen: 1'b0};
      packed_word    <= '0;
      long_code_base <= '0;
      pending_ticks  <= '0;
      index_neg      <= 1'b0;
      index_mag      <= '0;
    end else if (advance) begin
      ctrl           <= ctrl_next;
      packed_word    <= packed_word_next;
      long_code_base <= long_code_base_next;
      pending_ticks  <= pending_ticks_next;
      index_neg      <= index_neg_next;
      index_mag      <= index_mag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res    <= res;
      tick_value <= res_ticks;
    end
  end

  assign result_kind   = out_res.kind;
  assign error_code    = out_res.code;
  assign end_of_stream = out_res.eos;

  // The end-of-stream transaction is always a completion or an error.
  a_eos_kind : assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_stream |-> (result_kind == KIND_DONE || result_kind == KIND_ERROR))
    else $error("end of stream reported with a flux or index result");

  // An error code is present exactly on error results.
  a_code_kind : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((result_kind == KIND_ERROR) == (error_code != ERR_NONE)))
    else $error("error code does not agree with result kind");

  // Once an error is seen, ordinary bytes are swallowed.
  a_error_quiet : assert property (@(posedge clk) disable iff (rst)
    advance && ctrl.error_seen && !byte_last_q |-> !res_valid)
    else $error("result produced after an error");

  // The terminator byte returns the parser to its starting state.
  a_restart : assert property (@(posedge clk) disable iff (rst)
    advance && byte_last_q |=> ctrl.phase == PH_IDLE && !ctrl.error_seen &&
                               pending_ticks == '0 && !index_neg && index_mag == '0)
    else $error("parser state not cleared after the terminator byte");

endmodule
